/* sv/mfr_pkg.sv */
// Shared types, constants and helpers for the marked frame receiver.
// No dependencies; every other file of the block imports this package.
package mfr_pkg;

  localparam int BYTE_W     = 8;
  localparam int KIND_W     = 2;
  localparam int HDR_W      = 32;
  localparam int FLEN_W     = 5;
  localparam int PLEN_W     = 6;   // holds payload lengths up to 63
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [BYTE_W-1:0] START_CODE_RST = 8'hFE;
  localparam logic [HDR_W-1:0]  VAR_HDR_RST    = 32'h4853_4E44;
  localparam logic [FLEN_W-1:0] FIXED_LEN_RST  = 5'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_CODE = 2'd0,
    CFG_VAR_HEADER = 2'd1,
    CFG_FIXED_LEN  = 2'd2
  } cfg_idx_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_START   = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_PAYLOAD = 2'd2
  } byte_kind_t;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_HEADER,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_CHECK
  } phase_t;

  // One checked frame waiting for the back end; payload bytes sit in bank
  typedef struct packed {
    logic               bank;
    logic [PLEN_W-1:0]  len;
    logic [BYTE_W-1:0]  start;
    logic [HDR_W-1:0]   header;
  } frame_desc_t;

  // Payload byte write from the parser into the frame buffer
  typedef struct packed {
    logic               en;
    logic               bank;
    logic [PLEN_W-1:0]  idx;
    logic [BYTE_W-1:0]  data;
  } pay_wr_t;

  function automatic logic [3:0] ones8(input logic [BYTE_W-1:0] v);
    logic [3:0] c;
    c = 4'd0;
    for (int i = 0; i < BYTE_W; i++) begin
      c = c + 4'(v[i]);
    end
    return c;
  endfunction

endpackage

/* sv/mfr_if.sv */
// Valid/ready channel interfaces for received bytes and emitted frame bytes.
// Depends on mfr_pkg for field widths.
interface mfr_in_if import mfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mfr_out_if import mfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic [KIND_W-1:0] byte_kind;
  logic              last_of_frame;

  modport source (output valid, output out_byte, output byte_kind, output last_of_frame,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_kind, input last_of_frame,
                  output ready);
endinterface

/* sv/marked_frame_receiver_popcount_check.sv */
// Marked frame receiver with a set-bit count check.
// Input channel in_rx takes one received byte per accepted request, one per
// cycle while the frame queue has room. The parser hunts for the start code,
// collects a 4-byte header, an optional length byte and the payload, then
// compares the check byte with the set-bit count of header and payload modulo
// 256. A good frame is requested on out_tx as start byte, header bytes,
// payload bytes, one per cycle while out_tx.ready is high, the last marked; a
// bad or oversize frame is dropped with no output. A frame's first byte
// reaches out_tx through the descriptor queue and the output register after
// its check byte is accepted. Two checked frames can wait in the two-bank
// buffer; with both banks occupied in_rx.ready drops until the emitter retires
// a frame, so a stalled out_tx backs up into the input after at most two frames.
// Reset (rst_n low, synchronous) returns to hunting, empties the frame queue
// and loads start code 0xFE, header word "HSND" and fixed length 5.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect next cycle.
// Depends on mfr_pkg, mfr_if, mfr_front, mfr_queue and mfr_back.
module marked_frame_receiver_popcount_check import mfr_pkg::*; #(
  parameter int MAX_PAYLOAD = 28
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  mfr_in_if.sink                in_rx,
  mfr_out_if.source             out_tx
);

  logic        q_full;
  logic        q_empty;
  logic        push;
  logic        pop;
  frame_desc_t push_desc;
  frame_desc_t q_head;
  pay_wr_t     pay_wr;

  mfr_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_rx.valid),
    .in_byte   (in_rx.rx_byte),
    .in_ready  (in_rx.ready),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc),
    .pay_wr    (pay_wr)
  );

  mfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  mfr_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pay_wr    (pay_wr),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (pop),
    .out_valid (out_tx.valid),
    .out_ready (out_tx.ready),
    .out_byte  (out_tx.out_byte),
    .out_kind  (out_tx.byte_kind),
    .out_last  (out_tx.last_of_frame)
  );

endmodule

/* sv/mfr_front.sv */
// Front end: configuration registers and the byte parser (hunt, header, length,
// payload, check). Writes payload bytes to the frame buffer, requests on a match.
// Depends on mfr_pkg.
module mfr_front import mfr_pkg::*; #(
  parameter int MAX_PAYLOAD = 28
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic [BYTE_W-1:0]     in_byte,
  output logic                  in_ready,
  input  logic                  q_full,
  output logic                  push,
  output frame_desc_t           push_desc,
  output pay_wr_t               pay_wr
);

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

  phase_t              phase_r, phase_nxt;
  logic [1:0]          hdr_cnt_r, hdr_cnt_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    len_r, len_nxt;
  logic [BYTE_W-1:0]   sum_r, sum_nxt;
  logic [HDR_W-1:0]    hdr_r, hdr_nxt;
  logic                bank_r, bank_nxt;
  logic [BYTE_W-1:0]   start_code_r;
  logic [HDR_W-1:0]    var_hdr_r;
  logic [FLEN_W-1:0]   fixed_len_r;

  logic                acc;
  logic [HDR_W-1:0]    hdr_shift;
  logic                hdr_done;
  logic                hdr_var;
  logic                len_big_f;
  logic                len_big_b;
  logic [CNT_W-1:0]    cnt_inc;
  logic                pay_done;
  logic [BYTE_W-1:0]   sum_add;

  assign in_ready  = !q_full;
  assign acc       = in_valid && in_ready;
  assign hdr_shift = {hdr_r[HDR_W-BYTE_W-1:0], in_byte};
  assign hdr_done  = (hdr_cnt_r == 2'd3);
  assign hdr_var   = (hdr_shift == var_hdr_r);
  assign len_big_f = ({3'b000, fixed_len_r} > 8'(MAX_PAYLOAD));
  assign len_big_b = (in_byte > 8'(MAX_PAYLOAD));
  assign cnt_inc   = cnt_r + 1'b1;
  assign pay_done  = (cnt_inc >= len_r);
  assign sum_add   = sum_r + 8'(ones8(in_byte));

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      case (phase_r)
        PH_HUNT: begin
          if (in_byte == start_code_r) phase_nxt = PH_HEADER;
        end
        PH_HEADER: begin
          if (hdr_done) begin
            if (hdr_var)                 phase_nxt = PH_LENGTH;
            else if (len_big_f)          phase_nxt = PH_HUNT;
            else if (fixed_len_r == '0)  phase_nxt = PH_CHECK;
            else                         phase_nxt = PH_PAYLOAD;
          end
        end
        PH_LENGTH: begin
          if (len_big_b)              phase_nxt = PH_HUNT;
          else if (in_byte == '0)     phase_nxt = PH_CHECK;
          else                        phase_nxt = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (pay_done) phase_nxt = PH_CHECK;
        end
        PH_CHECK: phase_nxt = PH_HUNT;
        default:  phase_nxt = PH_HUNT;
      endcase
    end
  end

  // Datapath and outputs
  always_comb begin
    hdr_cnt_nxt = hdr_cnt_r;
    cnt_nxt     = cnt_r;
    len_nxt     = len_r;
    sum_nxt     = sum_r;
    hdr_nxt     = hdr_r;
    bank_nxt    = bank_r;
    push        = 1'b0;
    pay_wr.en   = 1'b0;
    pay_wr.bank = bank_r;
    pay_wr.idx  = PLEN_W'(cnt_r);
    pay_wr.data = in_byte;
    if (acc) begin
      case (phase_r)
        PH_HUNT: begin
          hdr_cnt_nxt = 2'd0;
          sum_nxt     = '0;
        end
        PH_HEADER: begin
          hdr_nxt     = hdr_shift;
          sum_nxt     = sum_add;
          hdr_cnt_nxt = hdr_cnt_r + 2'd1;
          if (hdr_done && !hdr_var) begin
            len_nxt = CNT_W'(fixed_len_r);
            cnt_nxt = '0;
          end
        end
        PH_LENGTH: begin
          len_nxt = CNT_W'(in_byte);
          cnt_nxt = '0;
        end
        PH_PAYLOAD: begin
          pay_wr.en = 1'b1;
          sum_nxt   = sum_add;
          cnt_nxt   = cnt_inc;
        end
        PH_CHECK: begin
          if (in_byte == sum_r) begin
            push     = 1'b1;
            bank_nxt = ~bank_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign push_desc.bank   = bank_r;
  assign push_desc.len    = PLEN_W'(len_r);
  assign push_desc.start  = start_code_r;
  assign push_desc.header = hdr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      hdr_cnt_r    <= '0;
      cnt_r        <= '0;
      len_r        <= '0;
      sum_r        <= '0;
      bank_r       <= 1'b0;
      start_code_r <= START_CODE_RST;
      var_hdr_r    <= VAR_HDR_RST;
      fixed_len_r  <= FIXED_LEN_RST;
    end else begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      cnt_r     <= cnt_nxt;
      len_r     <= len_nxt;
      sum_r     <= sum_nxt;
      bank_r    <= bank_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_CODE: start_code_r <= cfg_data[BYTE_W-1:0];
          CFG_VAR_HEADER: var_hdr_r    <= cfg_data[HDR_W-1:0];
          CFG_FIXED_LEN:  fixed_len_r  <= cfg_data[FLEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
  end

endmodule

/* sv/mfr_queue.sv */
// Two-entry queue of checked frame descriptors between parser and emitter.
// Depends on mfr_pkg.
module mfr_queue import mfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  frame_desc_t push_desc,
  output logic        full,
  input  logic        pop,
  output frame_desc_t head,
  output logic        empty
);

  frame_desc_t slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_desc;
  end

endmodule

/* sv/mfr_back.sv */
// Back end: two-bank payload buffer and the emitter that walks a frame out,
// start byte, four header bytes, then payload, through a registered output stage.
// Depends on mfr_pkg.
module mfr_back import mfr_pkg::*; #(
  parameter int MAX_PAYLOAD = 28
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pay_wr_t           pay_wr,
  input  logic              q_empty,
  input  frame_desc_t       q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic [KIND_W-1:0] out_kind,
  output logic              out_last
);

  localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int POS_W = $clog2(MAX_PAYLOAD + 5);

  logic [BYTE_W-1:0] mem [2][MAX_PAYLOAD];

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              s2_valid_r, s2_valid_nxt;
  byte_kind_t        s2_kind_r;
  logic              s2_last_r;
  logic [BYTE_W-1:0] s2_byte_r;
  logic [BYTE_W-1:0] rd_q_r;

  logic              adv;
  byte_kind_t        kind_cur;
  logic              last_cur;
  logic [1:0]        hdr_sel;
  logic [BYTE_W-1:0] byte_cur;
  logic [POS_W-1:0]  pidx;
  logic [IDX_W-1:0]  rd_idx;

  assign adv      = !q_empty && (!s2_valid_r || out_ready);
  assign last_cur = (7'(pos_r) == 7'(q_head.len) + 7'd4);
  assign hdr_sel  = 2'(pos_r - POS_W'(1));
  assign pidx     = pos_r - POS_W'(5);
  assign rd_idx   = pidx[IDX_W-1:0];

  always_comb begin
    if (pos_r == '0) begin
      kind_cur = KIND_START;
      byte_cur = q_head.start;
    end else if (pos_r <= POS_W'(4)) begin
      kind_cur = KIND_HEADER;
      byte_cur = q_head.header[8*(3-hdr_sel) +: 8];
    end else begin
      kind_cur = KIND_PAYLOAD;
      byte_cur = q_head.start;
    end
  end

  // Retire the descriptor once its last byte moves to the output stage
  always_comb begin
    q_pop        = adv && last_cur;
    pos_nxt      = pos_r;
    if (adv) pos_nxt = last_cur ? '0 : pos_r + 1'b1;
    s2_valid_nxt = adv ? 1'b1 : (out_ready ? 1'b0 : s2_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      s2_valid_r <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_kind_r <= kind_cur;
      s2_last_r <= last_cur;
      s2_byte_r <= byte_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (pay_wr.en) mem[pay_wr.bank][pay_wr.idx[IDX_W-1:0]] <= pay_wr.data;
    if (adv && kind_cur == KIND_PAYLOAD) rd_q_r <= mem[q_head.bank][rd_idx];
  end

  assign out_valid = s2_valid_r;
  assign out_byte  = (s2_kind_r == KIND_PAYLOAD) ? rd_q_r : s2_byte_r;
  assign out_kind  = s2_kind_r;
  assign out_last  = s2_last_r;

endmodule
